@@ sv/wprm_pkg.sv @@
// shared types, constants and ring index helpers for the windowed pulse rate meter
// no dependencies; used by every other file of the block
`default_nettype none

package wprm_pkg;

    localparam int RING_DEPTH = 16;
    localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int STAMP_W    = 32;
    localparam int DIV_STEPS  = STAMP_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // 60 s/min * 1000 ms/s * 256 for the 8 fraction bits
    localparam logic [STAMP_W-1:0] PPM_Q8_SCALE = STAMP_W'(60 * 1000 * 256);
    localparam logic [STAMP_W-1:0] RESET_WINDOW = STAMP_W'(60000);

    localparam logic CMD_PULSE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [STAMP_W-1:0]   t_stamp;
    typedef logic [DIV_CNT_W-1:0] t_div_cnt;

    typedef struct packed {
        logic   start;
        t_stamp num;
        t_stamp den;
    } t_div_req;

    typedef struct packed {
        logic   done;
        t_stamp quot;
    } t_div_rsp;

    function automatic t_slot slot_after(input t_slot i);
        t_slot r;
        if (i == t_slot'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = i + t_slot'(1);
        end
        return r;
    endfunction

    function automatic t_slot slot_before(input t_slot i);
        t_slot r;
        if (i == '0) begin
            r = t_slot'(RING_DEPTH - 1);
        end else begin
            r = i - t_slot'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/wprm_if.sv @@
// valid/ready channel interfaces for command input and result output
// depends on wprm_pkg for the stamp type
`default_nettype none

interface wprm_in_if;
    logic              valid;
    logic              ready;
    logic              command;
    wprm_pkg::t_stamp  now_ms;

    modport source (output valid, output command, output now_ms, input ready);
    modport sink   (input valid, input command, input now_ms, output ready);
endinterface

interface wprm_out_if;
    logic              valid;
    logic              ready;
    wprm_pkg::t_stamp  rate_ppm_q8;
    wprm_pkg::t_stamp  total_pulses;
    logic              no_recent_pulse;

    modport source (output valid, output rate_ppm_q8, output total_pulses,
                    output no_recent_pulse, input ready);
    modport sink   (input valid, input rate_ppm_q8, input total_pulses,
                    input no_recent_pulse, output ready);
endinterface

`default_nettype wire

@@ sv/wprm_ring_mem.sv @@
// time stamp ring: one write port, one read port, registered read data
// depends on wprm_pkg
`default_nettype none

module wprm_ring_mem (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire wprm_pkg::t_slot   i_wr_addr,
    input  wire wprm_pkg::t_stamp  i_wr_data,
    input  wire wprm_pkg::t_slot   i_rd_addr,
    output wprm_pkg::t_stamp       o_rd_data
);

    wprm_pkg::t_stamp r_mem [wprm_pkg::RING_DEPTH];
    wprm_pkg::t_stamp r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ sv/wprm_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on wprm_pkg; a zero divisor yields an all ones quotient
`default_nettype none

module wprm_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire wprm_pkg::t_div_req i_req,
    output wprm_pkg::t_div_rsp      o_rsp
);

    logic               r_busy;
    logic               r_done;
    wprm_pkg::t_div_cnt r_cnt;
    wprm_pkg::t_stamp   r_rem;
    wprm_pkg::t_stamp   r_quo;
    wprm_pkg::t_stamp   r_den;

    logic [wprm_pkg::STAMP_W:0] w_shift;
    logic [wprm_pkg::STAMP_W:0] w_diff;
    logic                       w_ge;

    assign w_shift = {r_rem, r_quo[wprm_pkg::STAMP_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[wprm_pkg::STAMP_W-1:0]
                          : w_shift[wprm_pkg::STAMP_W-1:0];
            r_quo <= {r_quo[wprm_pkg::STAMP_W-2:0], w_ge};
        end

        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + wprm_pkg::t_div_cnt'(1);
                if (r_cnt == wprm_pkg::t_div_cnt'(wprm_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

`default_nettype wire

@@ sv/windowed_pulse_rate_meter_unit.sv @@
// pulse transfer: stamp written to the ring when taken, next transfer may follow at once
// query: head check, walk back from the newest stamp, oldest read when the ring is full,
//   divider (start, steps, done), result load; input ready again once the result is loaded;
//   a stale head goes straight to the result load
// one item at a time; a finished result waits in the output register; synchronous active-low
//   reset clears valid bits, ring pointer and total and sets the window to 60000; needs wprm_* files
`default_nettype none

module windowed_pulse_rate_meter_unit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_wr_en,
    input  wire wprm_pkg::t_stamp i_cfg_wr_data,
    wprm_in_if.sink              i_in,
    wprm_out_if.source           o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_REF,
        S_DIV,
        S_RESP
    } t_state;

    t_state r_state, n_state;

    wprm_pkg::t_stamp                    r_window, n_window;
    logic [wprm_pkg::RING_DEPTH-1:0]     r_valid, n_valid;
    wprm_pkg::t_slot                     r_newest, n_newest;
    logic                                r_any, n_any;
    wprm_pkg::t_stamp                    r_total, n_total;
    wprm_pkg::t_stamp                    r_now, n_now;
    wprm_pkg::t_slot                     r_cur, n_cur;
    logic                                r_first, n_first;
    wprm_pkg::t_stamp                    r_num, n_num;
    wprm_pkg::t_stamp                    r_den, n_den;
    logic                                r_div_start, n_div_start;
    logic                                r_nrp, n_nrp;
    logic                                r_out_valid, n_out_valid;
    wprm_pkg::t_stamp                    r_out_rate, n_out_rate;
    wprm_pkg::t_stamp                    r_out_total, n_out_total;
    logic                                r_out_nrp, n_out_nrp;

    logic               w_accept;
    logic               w_wr_en;
    wprm_pkg::t_slot    w_wr_addr;
    wprm_pkg::t_slot    w_rd_addr;
    wprm_pkg::t_stamp   w_rd_data;
    wprm_pkg::t_stamp   w_age;
    wprm_pkg::t_slot    w_pulse_slot;
    wprm_pkg::t_div_req w_div_req;
    wprm_pkg::t_div_rsp w_div_rsp;

    wprm_ring_mem u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_in.now_ms),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_div_req.start = r_div_start;
    assign w_div_req.num   = r_num;
    assign w_div_req.den   = r_den;

    wprm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign i_in.ready   = (r_state == S_IDLE);
    assign w_accept     = i_in.valid && i_in.ready;
    assign w_age        = r_now - w_rd_data;
    assign w_pulse_slot = r_any ? wprm_pkg::slot_after(r_newest) : '0;
    assign w_wr_addr    = w_pulse_slot;

    always_comb begin
        n_state     = r_state;
        n_window    = r_window;
        n_valid     = r_valid;
        n_newest    = r_newest;
        n_any       = r_any;
        n_total     = r_total;
        n_now       = r_now;
        n_cur       = r_cur;
        n_first     = r_first;
        n_num       = r_num;
        n_den       = r_den;
        n_div_start = 1'b0;
        n_nrp       = r_nrp;
        n_out_valid = r_out_valid;
        n_out_rate  = r_out_rate;
        n_out_total = r_out_total;
        n_out_nrp   = r_out_nrp;
        w_wr_en     = 1'b0;
        w_rd_addr   = r_newest;

        if (i_cfg_wr_en) begin
            n_window = i_cfg_wr_data;
        end
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.command == wprm_pkg::CMD_PULSE) begin
                        w_wr_en               = 1'b1;
                        n_valid[w_pulse_slot] = 1'b1;
                        n_newest              = w_pulse_slot;
                        n_any                 = 1'b1;
                        n_total               = r_total + wprm_pkg::t_stamp'(1);
                    end else begin
                        // head read issued now, its data is checked in the first walk cycle
                        n_now   = i_in.now_ms;
                        n_cur   = r_newest;
                        n_first = 1'b1;
                        n_num   = '0;
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_first) begin
                    n_first = 1'b0;
                    if (!r_valid[r_cur] || (w_age > r_window)) begin
                        n_nrp   = 1'b1;
                        n_state = S_RESP;
                    end else begin
                        n_num     = wprm_pkg::PPM_Q8_SCALE;
                        n_cur     = wprm_pkg::slot_before(r_cur);
                        w_rd_addr = wprm_pkg::slot_before(r_cur);
                    end
                end else if (r_cur == r_newest) begin
                    // every slot counted: reference is the oldest stamp
                    w_rd_addr = wprm_pkg::slot_after(r_newest);
                    n_state   = S_REF;
                end else if (r_valid[r_cur] && (w_age < r_window)) begin
                    n_num     = r_num + wprm_pkg::PPM_Q8_SCALE;
                    n_cur     = wprm_pkg::slot_before(r_cur);
                    w_rd_addr = wprm_pkg::slot_before(r_cur);
                end else begin
                    // an empty slot stands for time zero
                    n_den       = r_valid[r_cur] ? w_age : r_now;
                    n_div_start = 1'b1;
                    n_nrp       = 1'b0;
                    n_state     = S_DIV;
                end
            end
            S_REF: begin
                n_den       = w_age;
                n_div_start = 1'b1;
                n_nrp       = 1'b0;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_rate  = r_nrp ? '0 : w_div_rsp.quot;
                    n_out_total = r_total;
                    n_out_nrp   = r_nrp;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_now       <= n_now;
        r_cur       <= n_cur;
        r_first     <= n_first;
        r_num       <= n_num;
        r_den       <= n_den;
        r_nrp       <= n_nrp;
        r_out_rate  <= n_out_rate;
        r_out_total <= n_out_total;
        r_out_nrp   <= n_out_nrp;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= wprm_pkg::RESET_WINDOW;
            r_valid     <= '0;
            r_newest    <= '0;
            r_any       <= 1'b0;
            r_total     <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_window    <= n_window;
            r_valid     <= n_valid;
            r_newest    <= n_newest;
            r_any       <= n_any;
            r_total     <= n_total;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.rate_ppm_q8     = r_out_rate;
    assign o_out.total_pulses    = r_out_total;
    assign o_out.no_recent_pulse = r_out_nrp;

`ifndef NO_ASSERTIONS
    a_nrp_zero_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.no_recent_pulse) |-> (o_out.rate_ppm_q8 == '0))
        else $error("no recent pulse reported with nonzero rate");

    a_pulse_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.command == wprm_pkg::CMD_PULSE))
            |=> (r_total == $past(r_total) + wprm_pkg::t_stamp'(1)))
        else $error("pulse transfer did not advance the total");

    a_newest_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.command == wprm_pkg::CMD_PULSE)) |=> r_valid[r_newest])
        else $error("newest slot not marked valid after a pulse");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");
`endif

endmodule

`default_nettype wire
